[hdl/flvhp_pkg.sv]
`default_nettype none

package flvhp_pkg;

  localparam logic [23:0] FlvSignature  = 24'h464C56;
  localparam logic [7:0]  FlvVersion    = 8'd1;
  localparam logic [31:0] FlvHdrOffset  = 32'd9;
  localparam logic [7:0]  TagTypeVideo  = 8'd9;

  localparam logic [3:0]  HdrIdxSigLast = 4'd2;
  localparam logic [3:0]  HdrIdxVersion = 4'd3;
  localparam logic [3:0]  HdrIdxFlags   = 4'd4;
  localparam logic [3:0]  HdrIdxLast    = 4'd8;

  localparam logic [3:0]  TagIdxType    = 4'd4;
  localparam logic [3:0]  TagIdxSize0   = 4'd5;
  localparam logic [3:0]  TagIdxSize2   = 4'd7;
  localparam logic [3:0]  TagIdxTime0   = 4'd8;
  localparam logic [3:0]  TagIdxTime2   = 4'd10;
  localparam logic [3:0]  TagIdxTimeExt = 4'd11;
  localparam logic [3:0]  TagIdxStream0 = 4'd12;
  localparam logic [3:0]  TagIdxLast    = 4'd14;

  typedef enum logic [1:0] {
    PH_FILE_HDR = 2'd0,
    PH_TAG_HDR  = 2'd1,
    PH_VID_BYTE = 2'd2,
    PH_SKIP     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_SIG     = 2'd1,
    FLT_VERSION = 2'd2,
    FLT_OFFSET  = 2'd3
  } fault_e;

  typedef enum logic {
    RES_FILE_HDR = 1'b0,
    RES_TAG      = 1'b1
  } res_kind_e;

  typedef struct packed {
    res_kind_e   result_kind;
    fault_e      header_status;
    logic        has_audio;
    logic        has_video;
    logic [7:0]  tag_kind;
    logic [23:0] payload_size;
    logic [23:0] time_low;
    logic [7:0]  time_high;
    logic        stream_nonzero;
    logic [3:0]  frame_kind;
    logic [3:0]  codec_kind;
    logic        codec_valid;
  } result_t;

endpackage

`default_nettype wire

[hdl/flvhp_parser.sv]
`default_nettype none

module flvhp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output logic                   res_valid_o,
  output flvhp_pkg::result_t     res_o
);
  import flvhp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [23:0] shift_q, shift_d;
  fault_e      fault_q, fault_d;
  logic [1:0]  media_q, media_d;
  logic [7:0]  kind_q, kind_d;
  logic [23:0] size_q, size_d;
  logic [23:0] time_q, time_d;
  logic [7:0]  time_hi_q, time_hi_d;
  logic        stream_bad_q, stream_bad_d;
  logic [23:0] left_q, left_d;

  logic [23:0] sig_word;
  logic [31:0] ofs_word;
  logic [23:0] left_dec;

  assign sig_word = {shift_q[15:0], byte_i};
  assign ofs_word = {shift_q, byte_i};
  assign left_dec = left_q - 24'd1;

  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    shift_d      = shift_q;
    fault_d      = fault_q;
    media_d      = media_q;
    kind_d       = kind_q;
    size_d       = size_q;
    time_d       = time_q;
    time_hi_d    = time_hi_q;
    stream_bad_d = stream_bad_q;
    left_d       = left_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    unique case (phase_q)
      PH_FILE_HDR: begin
        shift_d = sig_word;
        idx_d   = idx_q + 4'd1;
        if (idx_q == HdrIdxSigLast) begin
          if (sig_word != FlvSignature && fault_q == FLT_NONE) fault_d = FLT_SIG;
          shift_d = '0;
        end else if (idx_q == HdrIdxVersion) begin
          if (byte_i != FlvVersion && fault_q == FLT_NONE) fault_d = FLT_VERSION;
          shift_d = '0;
        end else if (idx_q == HdrIdxFlags) begin
          media_d = {byte_i[2], byte_i[0]};
          shift_d = '0;
        end else if (idx_q >= HdrIdxLast) begin
          if (ofs_word != FlvHdrOffset && fault_q == FLT_NONE) fault_d = FLT_OFFSET;
          res_valid_o         = 1'b1;
          res_o.result_kind   = RES_FILE_HDR;
          res_o.header_status = fault_d;
          res_o.has_audio     = media_q[1];
          res_o.has_video     = media_q[0];
          shift_d = '0;
          idx_d   = '0;
          phase_d = PH_TAG_HDR;
        end
      end
      PH_TAG_HDR: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == TagIdxType) begin
          kind_d       = byte_i;
          stream_bad_d = 1'b0;
        end else if (idx_q >= TagIdxSize0 && idx_q <= TagIdxSize2) begin
          size_d = {size_q[15:0], byte_i};
        end else if (idx_q >= TagIdxTime0 && idx_q <= TagIdxTime2) begin
          time_d = {time_q[15:0], byte_i};
        end else if (idx_q == TagIdxTimeExt) begin
          time_hi_d = byte_i;
        end else if (idx_q >= TagIdxStream0) begin
          if (byte_i != 8'd0) stream_bad_d = 1'b1;
          if (idx_q >= TagIdxLast) begin
            idx_d  = '0;
            left_d = size_q;
            if (kind_q == TagTypeVideo && size_q != '0) begin
              phase_d = PH_VID_BYTE;
            end else begin
              res_valid_o          = 1'b1;
              res_o.result_kind    = RES_TAG;
              res_o.tag_kind       = kind_q;
              res_o.payload_size   = size_q;
              res_o.time_low       = time_q;
              res_o.time_high      = time_hi_q;
              res_o.stream_nonzero = stream_bad_d;
              phase_d = (size_q != '0) ? PH_SKIP : PH_TAG_HDR;
            end
          end
        end
      end
      PH_VID_BYTE: begin
        res_valid_o          = 1'b1;
        res_o.result_kind    = RES_TAG;
        res_o.tag_kind       = kind_q;
        res_o.payload_size   = size_q;
        res_o.time_low       = time_q;
        res_o.time_high      = time_hi_q;
        res_o.stream_nonzero = stream_bad_q;
        res_o.frame_kind     = byte_i[7:4];
        res_o.codec_kind     = byte_i[3:0];
        res_o.codec_valid    = 1'b1;
        left_d  = left_dec;
        phase_d = (left_dec == '0) ? PH_TAG_HDR : PH_SKIP;
      end
      PH_SKIP: begin
        left_d  = left_dec;
        phase_d = (left_dec == '0) ? PH_TAG_HDR : PH_SKIP;
      end
      default: begin
        phase_d = PH_TAG_HDR;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FILE_HDR;
      idx_q        <= '0;
      shift_q      <= '0;
      fault_q      <= FLT_NONE;
      media_q      <= '0;
      kind_q       <= '0;
      size_q       <= '0;
      time_q       <= '0;
      time_hi_q    <= '0;
      stream_bad_q <= 1'b0;
      left_q       <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      shift_q      <= shift_d;
      fault_q      <= fault_d;
      media_q      <= media_d;
      kind_q       <= kind_d;
      size_q       <= size_d;
      time_q       <= time_d;
      time_hi_q    <= time_hi_d;
      stream_bad_q <= stream_bad_d;
      left_q       <= left_d;
    end
  end

endmodule

`default_nettype wire

[hdl/flv_stream_header_parser_core.sv]
// A word accepted into the input register moves on, with its result if it makes one,
// into the result register once that register is free or being read.
// Throughput: one input word per cycle unless the receiver stalls, set by the
// single parse step between the input register and the result register.
// Reset (rst_ni, async, active low) returns the parser to the file header and
// empties both registers.
`default_nettype none

module flv_stream_header_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [1:0]       header_status_o,
  output logic             has_audio_o,
  output logic             has_video_o,
  output logic [7:0]       tag_kind_o,
  output logic [23:0]      payload_size_o,
  output logic [23:0]      time_low_o,
  output logic [7:0]       time_high_o,
  output logic             stream_nonzero_o,
  output logic [3:0]       frame_kind_o,
  output logic [3:0]       codec_kind_o,
  output logic             codec_valid_o
);
  import flvhp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        advance;
  logic        res_valid;
  result_t     res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  flvhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.result_kind;
  assign header_status_o  = out_q.header_status;
  assign has_audio_o      = out_q.has_audio;
  assign has_video_o      = out_q.has_video;
  assign tag_kind_o       = out_q.tag_kind;
  assign payload_size_o   = out_q.payload_size;
  assign time_low_o       = out_q.time_low;
  assign time_high_o      = out_q.time_high;
  assign stream_nonzero_o = out_q.stream_nonzero;
  assign frame_kind_o     = out_q.frame_kind;
  assign codec_kind_o     = out_q.codec_kind;
  assign codec_valid_o    = out_q.codec_valid;

endmodule

`default_nettype wire

[hdl/flvhp_checker.sv]
`default_nettype none

module flvhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        result_kind_o,
  input wire logic [1:0]  header_status_o,
  input wire logic        has_audio_o,
  input wire logic        has_video_o,
  input wire logic [7:0]  tag_kind_o,
  input wire logic [23:0] payload_size_o,
  input wire logic        codec_valid_o,
  input wire logic [3:0]  frame_kind_o,
  input wire logic [3:0]  codec_kind_o
);
  import flvhp_pkg::*;

  // stalled word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_hdr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_FILE_HDR |->
      tag_kind_o == 8'd0 && payload_size_o == 24'd0 && !codec_valid_o)
    else $error("file header report carries tag fields");

  a_tag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_TAG |->
      header_status_o == FLT_NONE && !has_audio_o && !has_video_o)
    else $error("tag record carries header fields");

  a_codec_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && codec_valid_o |->
      result_kind_o == RES_TAG && tag_kind_o == TagTypeVideo && payload_size_o != 24'd0)
    else $error("codec nibbles on a non-video or empty tag");

  a_codec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !codec_valid_o |-> frame_kind_o == 4'd0 && codec_kind_o == 4'd0)
    else $error("codec nibbles set without codec_valid");

endmodule

bind flv_stream_header_parser_core flvhp_checker u_flvhp_checker (.*);

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  import flvhp_pkg::*;

  class flv_record_board;
    phase_e      step_phase = PH_FILE_HDR;
    logic [3:0]  hdr_pos = '0;
    logic [31:0] hdr_shift = '0;
    fault_e      hdr_fault = FLT_NONE;
    logic [1:0]  av_flags = '0;
    logic [7:0]  tag_code = '0;
    logic [23:0] tag_len = '0;
    logic [23:0] tag_ts = '0;
    logic [7:0]  tag_ts_ext = '0;
    logic        tag_sid_set = 1'b0;
    logic [23:0] bytes_to_skip = '0;
    result_t     pending[$];
    int          mismatches = 0;

    function result_t tag_record(bit has_codec, logic [7:0] b);
      result_t r;
      r = '0;
      r.result_kind    = RES_TAG;
      r.tag_kind       = tag_code;
      r.payload_size   = tag_len;
      r.time_low       = tag_ts;
      r.time_high      = tag_ts_ext;
      r.stream_nonzero = tag_sid_set;
      if (has_codec) begin
        r.frame_kind  = b[7:4];
        r.codec_kind  = b[3:0];
        r.codec_valid = 1'b1;
      end
      return r;
    endfunction

    function void eat_payload();
      bytes_to_skip = bytes_to_skip - 24'd1;
      step_phase = (bytes_to_skip == '0) ? PH_TAG_HDR : PH_SKIP;
    endfunction

    // one accepted word in, expected records queued
    function void take_byte(logic [7:0] b);
      result_t r;
      r = '0;
      case (step_phase)
        PH_FILE_HDR: begin
          hdr_shift = {hdr_shift[23:0], b};
          if (hdr_pos == HdrIdxSigLast) begin
            if (hdr_shift[23:0] != FlvSignature && hdr_fault == FLT_NONE) hdr_fault = FLT_SIG;
            hdr_shift = '0;
          end else if (hdr_pos == HdrIdxVersion) begin
            if (b != FlvVersion && hdr_fault == FLT_NONE) hdr_fault = FLT_VERSION;
            hdr_shift = '0;
          end else if (hdr_pos == HdrIdxFlags) begin
            av_flags = {b[2], b[0]};
            hdr_shift = '0;
          end else if (hdr_pos >= HdrIdxLast) begin
            if (hdr_shift != FlvHdrOffset && hdr_fault == FLT_NONE) hdr_fault = FLT_OFFSET;
            r.result_kind   = RES_FILE_HDR;
            r.header_status = hdr_fault;
            r.has_audio     = av_flags[1];
            r.has_video     = av_flags[0];
            pending.insert(pending.size(), r);
            hdr_shift  = '0;
            hdr_pos    = '0;
            step_phase = PH_TAG_HDR;
            return;
          end
          hdr_pos = hdr_pos + 4'd1;
        end
        PH_VID_BYTE: begin
          pending.insert(pending.size(), tag_record(1'b1, b));
          eat_payload();
        end
        PH_SKIP: begin
          eat_payload();
        end
        default: begin
          if (hdr_pos == TagIdxType) begin
            tag_code    = b;
            tag_sid_set = 1'b0;
          end else if (hdr_pos >= TagIdxSize0 && hdr_pos <= TagIdxSize2) begin
            tag_len = {tag_len[15:0], b};
          end else if (hdr_pos >= TagIdxTime0 && hdr_pos <= TagIdxTime2) begin
            tag_ts = {tag_ts[15:0], b};
          end else if (hdr_pos == TagIdxTimeExt) begin
            tag_ts_ext = b;
          end else if (hdr_pos >= TagIdxStream0) begin
            if (b != 8'd0) tag_sid_set = 1'b1;
            if (hdr_pos >= TagIdxLast) begin
              hdr_pos = '0;
              bytes_to_skip = tag_len;
              if (tag_code == TagTypeVideo && bytes_to_skip != '0) begin
                step_phase = PH_VID_BYTE;
                return;
              end
              pending.insert(pending.size(), tag_record(1'b0, 8'd0));
              step_phase = (bytes_to_skip != '0) ? PH_SKIP : PH_TAG_HDR;
              return;
            end
          end
          hdr_pos = hdr_pos + 4'd1;
        end
      endcase
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_record(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("record out with none expected");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("header_status", want.header_status, got.header_status);
      check_field("has_audio", want.has_audio, got.has_audio);
      check_field("has_video", want.has_video, got.has_video);
      check_field("tag_kind", want.tag_kind, got.tag_kind);
      check_field("payload_size", want.payload_size, got.payload_size);
      check_field("time_low", want.time_low, got.time_low);
      check_field("time_high", want.time_high, got.time_high);
      check_field("stream_nonzero", want.stream_nonzero, got.stream_nonzero);
      check_field("frame_kind", want.frame_kind, got.frame_kind);
      check_field("codec_kind", want.codec_kind, got.codec_kind);
      check_field("codec_valid", want.codec_valid, got.codec_valid);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [1:0]  header_status_o;
  logic        has_audio_o;
  logic        has_video_o;
  logic [7:0]  tag_kind_o;
  logic [23:0] payload_size_o;
  logic [23:0] time_low_o;
  logic [7:0]  time_high_o;
  logic        stream_nonzero_o;
  logic [3:0]  frame_kind_o;
  logic [3:0]  codec_kind_o;
  logic        codec_valid_o;

  flv_record_board board = new();
  flv_record_board planner = new();
  logic [7:0]      flv_bytes[$];
  bit              calm = 1'b0;
  bit              rst_done = 1'b0;

  flv_stream_header_parser_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .out_valid_o,
    .out_ready_i,
    .result_kind_o,
    .header_status_o,
    .has_audio_o,
    .has_video_o,
    .tag_kind_o,
    .payload_size_o,
    .time_low_o,
    .time_high_o,
    .stream_nonzero_o,
    .frame_kind_o,
    .codec_kind_o,
    .codec_valid_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.take_byte(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        board.match_record(result_t'({result_kind_o, header_status_o, has_audio_o,
          has_video_o, tag_kind_o, payload_size_o, time_low_o, time_high_o,
          stream_nonzero_o, frame_kind_o, codec_kind_o, codec_valid_o}));
      end
    end
  end

  // clamp size high/mid bytes while generating so a misaligned parse never skips far
  function automatic void push_byte(logic [7:0] b, bit guard);
    logic [7:0] v;
    v = b;
    if (guard && planner.step_phase == PH_TAG_HDR &&
        (planner.hdr_pos == TagIdxSize0 || planner.hdr_pos == TagIdxSize0 + 4'd1)) v = 8'd0;
    flv_bytes.insert(flv_bytes.size(), v);
    planner.take_byte(v);
  endfunction

  function automatic void push_tag(logic [7:0] kind, logic [23:0] len, logic [23:0] ts,
                                   logic [7:0] ext, logic [23:0] sid, int body, bit guard);
    int k;
    repeat (4) push_byte(8'($urandom), guard);
    push_byte(kind, guard);
    for (k = 2; k >= 0; k--) push_byte(len[8*k +: 8], guard);
    for (k = 2; k >= 0; k--) push_byte(ts[8*k +: 8], guard);
    push_byte(ext, guard);
    for (k = 2; k >= 0; k--) push_byte(sid[8*k +: 8], guard);
    repeat (body) push_byte(8'($urandom), guard);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // receiver: long hold-off first so the parser backs up, then random stall bursts
  initial begin
    wait (rst_done);
    repeat (300) @(negedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0]  hdr[9];
    logic [7:0]  kind;
    logic [23:0] len;
    logic [23:0] sid;
    int          k;

    hdr[0] = FlvSignature[23:16];
    hdr[1] = FlvSignature[15:8];
    hdr[2] = FlvSignature[7:0];
    hdr[3] = FlvVersion;
    hdr[4] = 8'($urandom);
    hdr[5] = FlvHdrOffset[31:24];
    hdr[6] = FlvHdrOffset[23:16];
    hdr[7] = FlvHdrOffset[15:8];
    hdr[8] = FlvHdrOffset[7:0];
    if ($urandom_range(0, 1) == 1) hdr[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0) hdr[3] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(0, 2) == 0) hdr[$urandom_range(5, 8)] ^= 8'(1 << $urandom_range(0, 7));
    for (k = 0; k < 9; k++) push_byte(hdr[k], 1'b0);

    // video tag, one payload byte, all-ones timestamp and stream id
    push_tag(TagTypeVideo, 24'd1, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 1, 1'b1);

    while (flv_bytes.size() < 1450) begin
      case ($urandom_range(0, 5))
        0, 1:    kind = 8'd8;
        2, 3:    kind = TagTypeVideo;
        4:       kind = 8'd18;
        default: kind = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    len = '0;
        9:       len = 24'($urandom_range(7, 255));
        default: len = 24'($urandom_range(1, 6));
      endcase
      sid = ($urandom_range(0, 3) == 0) ? 24'($urandom) : '0;
      push_tag(kind, len, 24'($urandom), 8'($urandom), sid, int'(len), 1'b1);
      if ($urandom_range(0, 11) == 0) begin
        // stray words, then filler until the parser is back at a tag boundary
        repeat ($urandom_range(1, 20)) push_byte(8'($urandom), 1'b1);
        while (!(planner.step_phase == PH_TAG_HDR && planner.hdr_pos == '0))
          push_byte(8'($urandom), 1'b1);
      end
    end
    // largest size last; its payload is never finished
    push_tag(TagTypeVideo, 24'hFFFFFF, 24'($urandom), 8'($urandom), '0, 3, 1'b0);

    repeat (12) @(negedge clk_i);
    rst_ni   <= 1'b1;
    rst_done = 1'b1;
    @(negedge clk_i);

    for (k = 0; k < flv_bytes.size(); k++) begin
      calm = (k + 150 >= flv_bytes.size());
      send_byte(flv_bytes[k], !calm);
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
